// ===== design/sdg_pkg.sv =====
`timescale 1ns / 1ps

package sdg_pkg;

    // Stream and sample format.
    localparam int SAMPLE_BITS     = 24;
    localparam int TDATA_W         = ((SAMPLE_BITS + 7) / 8) * 8;

    // Exponential table: EXP_TABLE_DEPTH + 1 entries of 2^(i/depth) in Q1.20.
    localparam int EXP_TABLE_DEPTH = 64;
    localparam int TI_W            = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int TAB_W           = 22;

    // Configuration registers.
    localparam int CFG_W           = 25;
    localparam int CFG_ADDR_W      = 2;
    localparam int TGT_W           = 16;

    localparam logic [CFG_ADDR_W-1:0] CFG_TARGET_GAIN_DB    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_INPUT_COEFFICIENT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_STATE_COEFFICIENT = 2'd2;

    localparam logic signed [TGT_W-1:0] TARGET_RESET = 16'sd0;
    localparam logic [CFG_W-1:0]        COEF_A_RESET = 25'd1747;
    localparam logic [CFG_W-1:0]        COEF_B_RESET = 25'd16775469;

    // Shared multiplier: signed 33 x signed 26.
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 26;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Datapath widths.
    localparam int Z_W     = 32;
    localparam int Y_W     = 34;
    localparam int YC_W    = 24;
    localparam int E_W     = 22;
    localparam int N_W     = 6;
    localparam int DIFF_W  = TAB_W + 1;
    localparam int W_W     = 16;
    localparam int DELTA_W = 24;
    localparam int M_W     = 25;
    localparam int SH_W    = 34;
    localparam int RATIO_W = 24;

    localparam logic signed [YC_W-1:0]   DB_MIN_Q16    = -24'sd4718592;
    localparam logic signed [YC_W-1:0]   DB_MAX_Q16    = 24'sd1572864;
    localparam logic [21:0]              LOG2_10_OVER_20_Q24 = 22'd2786635;
    localparam logic [63:0]              LN2_Q32       = 64'hB17217F8;
    localparam logic [RATIO_W-1:0]       RATIO_MAX     = 24'hFFFFFF;
    localparam logic signed [N_W-1:0]    N_SHL_MAX     = 6'sd8;
    localparam logic signed [Z_W-1:0]    Z_MIN         = {1'b1, {(Z_W-1){1'b0}}};
    localparam logic signed [Z_W-1:0]    Z_MAX         = {1'b0, {(Z_W-1){1'b1}}};

    // Rounding offsets for the arithmetic right shifts.
    localparam logic signed [PROD_W-1:0] HALF_Q24 = PROD_W'(1) << 23;
    localparam logic signed [PROD_W-1:0] HALF_Q20 = PROD_W'(1) << 19;
    localparam logic signed [PROD_W-1:0] HALF_Q16 = PROD_W'(1) << 15;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_TARGET,
        ST_MUL_STATE,
        ST_SUM,
        ST_MUL_LOG,
        ST_LOOKUP,
        ST_MUL_INTERP,
        ST_SCALE,
        ST_MUL_SAMPLE,
        ST_ROUND
    } t_state;

    typedef enum logic [2:0] {
        OP_TARGET,
        OP_STATE,
        OP_LOG,
        OP_INTERP,
        OP_SAMPLE
    } t_mul_op;

    typedef struct packed {
        logic    in_ready;
        logic    ld_x;
        logic    mul_en;
        t_mul_op mul_op;
        logic    ld_acc;
        logic    ld_y;
        logic    upd_z;
        logic    ld_lookup;
        logic    ld_ratio;
        logic    ld_out;
    } t_ctrl;

    // One table entry, 2^(i/EXP_TABLE_DEPTH) in Q1.20, from a 32-bit
    // fixed-point exponential series. Only ever called with constants.
    function automatic logic [TAB_W-1:0] pow2_frac_q20(input int unsigned i);
        logic [63:0] x;
        logic [63:0] t;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] rnd;
        x    = (64'(i) << 32) / EXP_TABLE_DEPTH;
        t    = (x * LN2_Q32) >> 32;
        term = 64'd1 << 32;
        sum  = term;
        for (int k = 1; k <= 24; k++) begin
            term = ((term * t) >> 32) / 64'(k);
            sum  = sum + term;
        end
        rnd = (sum + 64'd2048) >> 12;
        return rnd[TAB_W-1:0];
    endfunction

endpackage

// ===== design/sdg_mul.sv =====
`timescale 1ns / 1ps

module sdg_mul (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [sdg_pkg::MUL_A_W-1:0]   i_a,
    input  logic signed [sdg_pkg::MUL_B_W-1:0]   i_b,
    output logic signed [sdg_pkg::PROD_W-1:0]    o_prod
);

    logic signed [sdg_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== design/sdg_exp_table.sv =====
`timescale 1ns / 1ps

module sdg_exp_table (
    input  logic [sdg_pkg::TI_W-1:0]  i_idx,
    output logic [sdg_pkg::TAB_W-1:0] o_lo,
    output logic [sdg_pkg::TAB_W-1:0] o_hi
);

    logic [sdg_pkg::TAB_W-1:0] w_table [0:sdg_pkg::EXP_TABLE_DEPTH];
    logic [sdg_pkg::TI_W-1:0]  w_idx_hi;

    for (genvar g = 0; g <= sdg_pkg::EXP_TABLE_DEPTH; g++) begin : g_entry
        assign w_table[g] = sdg_pkg::pow2_frac_q20(g);
    end

    // The index never exceeds depth - 1, so the upper neighbor always exists.
    assign w_idx_hi = i_idx + sdg_pkg::TI_W'(1);
    assign o_lo     = w_table[i_idx];
    assign o_hi     = w_table[w_idx_hi];

endmodule

// ===== design/sdg_ctrl.sv =====
`timescale 1ns / 1ps

module sdg_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_out_free,
    output sdg_pkg::t_ctrl  o_ctrl
);

    sdg_pkg::t_state r_state;
    sdg_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sdg_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sdg_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = sdg_pkg::ST_MUL_TARGET;
                end
            end
            sdg_pkg::ST_MUL_TARGET: n_state = sdg_pkg::ST_MUL_STATE;
            sdg_pkg::ST_MUL_STATE:  n_state = sdg_pkg::ST_SUM;
            sdg_pkg::ST_SUM:        n_state = sdg_pkg::ST_MUL_LOG;
            sdg_pkg::ST_MUL_LOG:    n_state = sdg_pkg::ST_LOOKUP;
            sdg_pkg::ST_LOOKUP:     n_state = sdg_pkg::ST_MUL_INTERP;
            sdg_pkg::ST_MUL_INTERP: n_state = sdg_pkg::ST_SCALE;
            sdg_pkg::ST_SCALE:      n_state = sdg_pkg::ST_MUL_SAMPLE;
            sdg_pkg::ST_MUL_SAMPLE: n_state = sdg_pkg::ST_ROUND;
            sdg_pkg::ST_ROUND: begin
                // The next request may enter in the same cycle the result leaves.
                if (i_out_free) begin
                    n_state = i_in_valid ? sdg_pkg::ST_MUL_TARGET : sdg_pkg::ST_IDLE;
                end
            end
            default: n_state = sdg_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl           = '0;
        o_ctrl.mul_op    = sdg_pkg::OP_TARGET;
        unique case (r_state)
            sdg_pkg::ST_IDLE: begin
                o_ctrl.in_ready = 1'b1;
                o_ctrl.ld_x     = i_in_valid;
            end
            sdg_pkg::ST_MUL_TARGET: begin
                o_ctrl.mul_en = 1'b1;
                o_ctrl.mul_op = sdg_pkg::OP_TARGET;
            end
            sdg_pkg::ST_MUL_STATE: begin
                o_ctrl.mul_en = 1'b1;
                o_ctrl.mul_op = sdg_pkg::OP_STATE;
                o_ctrl.ld_acc = 1'b1;
            end
            sdg_pkg::ST_SUM: begin
                o_ctrl.ld_y = 1'b1;
            end
            sdg_pkg::ST_MUL_LOG: begin
                o_ctrl.mul_en = 1'b1;
                o_ctrl.mul_op = sdg_pkg::OP_LOG;
                o_ctrl.upd_z  = 1'b1;
            end
            sdg_pkg::ST_LOOKUP: begin
                o_ctrl.ld_lookup = 1'b1;
            end
            sdg_pkg::ST_MUL_INTERP: begin
                o_ctrl.mul_en = 1'b1;
                o_ctrl.mul_op = sdg_pkg::OP_INTERP;
            end
            sdg_pkg::ST_SCALE: begin
                o_ctrl.ld_ratio = 1'b1;
            end
            sdg_pkg::ST_MUL_SAMPLE: begin
                o_ctrl.mul_en = 1'b1;
                o_ctrl.mul_op = sdg_pkg::OP_SAMPLE;
            end
            sdg_pkg::ST_ROUND: begin
                o_ctrl.ld_out   = i_out_free;
                o_ctrl.in_ready = i_out_free;
                o_ctrl.ld_x     = i_out_free & i_in_valid;
            end
            default: begin
                o_ctrl.in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== design/smoothed_db_gain_stage.sv =====
// A request steps through MUL_TARGET, MUL_STATE, SUM, MUL_LOG, LOOKUP, MUL_INTERP, SCALE,
// MUL_SAMPLE and ROUND, using the shared 33 x 26 multiplier five times; ROUND stores the
// result once the output is free, and the next request may enter in that same cycle.
// Reset: i_rst_n is synchronous and active low; it empties the sequencer and the output
// register, clears the smoother state and loads the register defaults.
`timescale 1ns / 1ps

module smoothed_db_gain_stage (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sdg_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [sdg_pkg::CFG_W-1:0]         i_cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [sdg_pkg::TDATA_W-1:0]       s_tdata,   // [23:0] sample_in
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [sdg_pkg::TDATA_W-1:0]       m_tdata    // [23:0] sample_out
);

    localparam int SB = sdg_pkg::SAMPLE_BITS;

    localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};
    localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};

    sdg_pkg::t_ctrl w_ctrl;

    // Configuration registers.
    logic signed [sdg_pkg::TGT_W-1:0]   r_target;
    logic [sdg_pkg::CFG_W-1:0]          r_coef_a;
    logic [sdg_pkg::CFG_W-1:0]          r_coef_b;

    // Datapath registers.
    logic signed [SB-1:0]               r_x;
    logic signed [sdg_pkg::PROD_W-1:0]  r_acc;
    logic signed [sdg_pkg::Y_W-1:0]     r_y;
    logic signed [sdg_pkg::Z_W-1:0]     r_z;
    logic [sdg_pkg::TAB_W-1:0]          r_lo;
    logic signed [sdg_pkg::DIFF_W-1:0]  r_diff;
    logic [sdg_pkg::W_W-1:0]            r_w;
    logic signed [sdg_pkg::N_W-1:0]     r_n;
    logic [sdg_pkg::RATIO_W-1:0]        r_ratio;
    logic                               r_out_valid;
    logic [SB-1:0]                      r_out_data;

    logic signed [sdg_pkg::MUL_A_W-1:0] w_mul_a;
    logic signed [sdg_pkg::MUL_B_W-1:0] w_mul_b;
    logic signed [sdg_pkg::PROD_W-1:0]  w_prod;
    logic                               w_out_free;

    logic signed [sdg_pkg::PROD_W-1:0]  w_acc_sum;
    logic signed [sdg_pkg::Y_W+1:0]     w_z_wide;
    logic signed [sdg_pkg::Z_W-1:0]     w_z_next;
    logic signed [sdg_pkg::YC_W-1:0]    w_yc;

    logic signed [sdg_pkg::PROD_W-1:0]  w_e_sum;
    logic signed [sdg_pkg::E_W-1:0]     w_e;
    logic [sdg_pkg::W_W+sdg_pkg::TI_W-1:0] w_p;
    logic [sdg_pkg::TI_W-1:0]           w_idx;
    logic [sdg_pkg::TAB_W-1:0]          w_tab_lo;
    logic [sdg_pkg::TAB_W-1:0]          w_tab_hi;

    logic signed [sdg_pkg::PROD_W-1:0]  w_i_sum;
    logic signed [sdg_pkg::DELTA_W-1:0] w_delta;
    logic signed [sdg_pkg::M_W-1:0]     w_m;
    logic signed [sdg_pkg::SH_W-1:0]    w_m_ext;
    logic [sdg_pkg::N_W-1:0]            w_s;
    logic signed [sdg_pkg::SH_W-1:0]    w_rnd;
    logic signed [sdg_pkg::SH_W-1:0]    w_shift;
    logic [sdg_pkg::RATIO_W-1:0]        w_ratio;

    logic signed [sdg_pkg::PROD_W-1:0]  w_o_sum;
    logic signed [sdg_pkg::PROD_W-21:0] w_o;
    logic [SB-1:0]                      w_out;

    sdg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .i_out_free (w_out_free),
        .o_ctrl     (w_ctrl)
    );

    sdg_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_ctrl.mul_en),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    sdg_exp_table u_table (
        .i_idx (w_idx),
        .o_lo  (w_tab_lo),
        .o_hi  (w_tab_hi)
    );

    assign w_out_free = ~r_out_valid | m_tready;
    assign s_tready   = w_ctrl.in_ready;
    assign m_tvalid   = r_out_valid;
    assign m_tdata    = sdg_pkg::TDATA_W'(r_out_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= sdg_pkg::TARGET_RESET;
            r_coef_a <= sdg_pkg::COEF_A_RESET;
            r_coef_b <= sdg_pkg::COEF_B_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                sdg_pkg::CFG_TARGET_GAIN_DB:    r_target <= i_cfg_wdata[sdg_pkg::TGT_W-1:0];
                sdg_pkg::CFG_INPUT_COEFFICIENT: r_coef_a <= i_cfg_wdata;
                sdg_pkg::CFG_STATE_COEFFICIENT: r_coef_b <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        unique case (w_ctrl.mul_op)
            sdg_pkg::OP_TARGET: begin
                w_mul_a = {{(sdg_pkg::MUL_A_W-sdg_pkg::TGT_W-8){r_target[sdg_pkg::TGT_W-1]}},
                           r_target, 8'd0};
                w_mul_b = {1'b0, r_coef_a};
            end
            sdg_pkg::OP_STATE: begin
                w_mul_a = {{(sdg_pkg::MUL_A_W-sdg_pkg::Z_W){r_z[sdg_pkg::Z_W-1]}}, r_z};
                w_mul_b = {1'b0, r_coef_b};
            end
            sdg_pkg::OP_LOG: begin
                w_mul_a = {{(sdg_pkg::MUL_A_W-sdg_pkg::YC_W){w_yc[sdg_pkg::YC_W-1]}}, w_yc};
                w_mul_b = sdg_pkg::MUL_B_W'(sdg_pkg::LOG2_10_OVER_20_Q24);
            end
            sdg_pkg::OP_INTERP: begin
                w_mul_a = {{(sdg_pkg::MUL_A_W-sdg_pkg::DIFF_W){r_diff[sdg_pkg::DIFF_W-1]}},
                           r_diff};
                w_mul_b = sdg_pkg::MUL_B_W'(r_w);
            end
            sdg_pkg::OP_SAMPLE: begin
                w_mul_a = {{(sdg_pkg::MUL_A_W-SB){r_x[SB-1]}}, r_x};
                w_mul_b = sdg_pkg::MUL_B_W'(r_ratio);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // Smoother: y = round(a*target + b*z), then z = 2y - z saturated.
    assign w_acc_sum = r_acc + w_prod + sdg_pkg::HALF_Q24;
    assign w_z_wide  = {r_y[sdg_pkg::Y_W-1], r_y, 1'b0}
                     - {{(sdg_pkg::Y_W+2-sdg_pkg::Z_W){r_z[sdg_pkg::Z_W-1]}}, r_z};

    always_comb begin
        if (w_z_wide < sdg_pkg::Z_MIN) begin
            w_z_next = sdg_pkg::Z_MIN;
        end else if (w_z_wide > sdg_pkg::Z_MAX) begin
            w_z_next = sdg_pkg::Z_MAX;
        end else begin
            w_z_next = w_z_wide[sdg_pkg::Z_W-1:0];
        end
    end

    always_comb begin
        if (r_y < sdg_pkg::DB_MIN_Q16) begin
            w_yc = sdg_pkg::DB_MIN_Q16;
        end else if (r_y > sdg_pkg::DB_MAX_Q16) begin
            w_yc = sdg_pkg::DB_MAX_Q16;
        end else begin
            w_yc = r_y[sdg_pkg::YC_W-1:0];
        end
    end

    // Exponent split: integer part becomes a shift, fraction indexes the table.
    assign w_e_sum = w_prod + sdg_pkg::HALF_Q24;
    assign w_e     = w_e_sum[sdg_pkg::E_W+23:24];
    assign w_p     = (sdg_pkg::W_W+sdg_pkg::TI_W)'(w_e[sdg_pkg::W_W-1:0])
                   * (sdg_pkg::W_W+sdg_pkg::TI_W)'(sdg_pkg::EXP_TABLE_DEPTH);
    assign w_idx   = w_p[sdg_pkg::W_W+sdg_pkg::TI_W-1:sdg_pkg::W_W];

    // Interpolated mantissa and the power-of-two scaling.
    assign w_i_sum = w_prod + sdg_pkg::HALF_Q16;
    assign w_delta = w_i_sum[sdg_pkg::DELTA_W+15:16];
    assign w_m     = sdg_pkg::M_W'(r_lo) + {w_delta[sdg_pkg::DELTA_W-1], w_delta};
    assign w_m_ext = {{(sdg_pkg::SH_W-sdg_pkg::M_W){w_m[sdg_pkg::M_W-1]}}, w_m};
    assign w_s     = -r_n;
    assign w_rnd   = sdg_pkg::SH_W'(1) << (w_s - sdg_pkg::N_W'(1));

    always_comb begin
        if (!r_n[sdg_pkg::N_W-1]) begin
            w_shift = w_m_ext <<< r_n[3:0];
        end else begin
            w_shift = (w_m_ext + w_rnd) >>> w_s;
        end
        if (!r_n[sdg_pkg::N_W-1] && (r_n > sdg_pkg::N_SHL_MAX)) begin
            w_ratio = sdg_pkg::RATIO_MAX;
        end else if (w_shift[sdg_pkg::SH_W-1]) begin
            w_ratio = '0;
        end else if (w_shift > $signed({1'b0, sdg_pkg::RATIO_MAX})) begin
            w_ratio = sdg_pkg::RATIO_MAX;
        end else begin
            w_ratio = w_shift[sdg_pkg::RATIO_W-1:0];
        end
    end

    // Final rounding and saturation of the scaled sample.
    assign w_o_sum = w_prod + sdg_pkg::HALF_Q20;
    assign w_o     = w_o_sum[sdg_pkg::PROD_W-1:20];

    always_comb begin
        if (w_o < S_MIN) begin
            w_out = S_MIN;
        end else if (w_o > S_MAX) begin
            w_out = S_MAX;
        end else begin
            w_out = w_o[SB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.ld_x) begin
            r_x <= s_tdata[SB-1:0];
        end
        if (w_ctrl.ld_acc) begin
            r_acc <= w_prod;
        end
        if (w_ctrl.ld_y) begin
            r_y <= w_acc_sum[sdg_pkg::Y_W+23:24];
        end
        if (w_ctrl.ld_lookup) begin
            r_lo   <= w_tab_lo;
            r_diff <= {1'b0, w_tab_hi} - {1'b0, w_tab_lo};
            r_w    <= w_p[sdg_pkg::W_W-1:0];
            r_n    <= w_e[sdg_pkg::E_W-1:16];
        end
        if (w_ctrl.ld_ratio) begin
            r_ratio <= w_ratio;
        end
        if (w_ctrl.ld_out) begin
            r_out_data <= w_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_z         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_ctrl.upd_z) begin
                r_z <= w_z_next;
            end
            if (w_ctrl.ld_out) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== design/sdg_checker.sv =====
`timescale 1ns / 1ps

module sdg_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_s_tvalid,
    input logic                         i_s_tready,
    input logic                         i_m_tvalid,
    input logic                         i_m_tready,
    input logic [sdg_pkg::TDATA_W-1:0]  i_m_tdata
);

    // A result that is not taken stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready) |=> (i_m_tvalid && $stable(i_m_tdata)))
        else $error("stalled result changed or dropped");

    // One request at a time: no second request right after an accepted one.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && i_s_tready) |=> !i_s_tready)
        else $error("request taken while the previous one is in progress");

    // A fresh request must not produce a result too early.
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && i_s_tready) |-> ##2 !$rose(i_m_tvalid))
        else $error("result appeared too early after a request");

    // Reset empties the output and leaves the block ready.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!i_m_tvalid && i_s_tready))
        else $error("reset did not return the block to idle");

endmodule

bind smoothed_db_gain_stage sdg_checker u_sdg_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_tvalid),
    .i_s_tready (s_tready),
    .i_m_tvalid (m_tvalid),
    .i_m_tready (m_tready),
    .i_m_tdata  (m_tdata)
);
